// File: design/fds_pkg.sv
// Package with the word types, constants and the duration lookup of the frame sequencer.
package fds_pkg;

    localparam int MAX_FRAMES    = 8;
    localparam int DURATION_BITS = 16;
    localparam int SLOT_BITS     = 16;
    localparam int POS_W         = 3;
    localparam int COUNT_W       = 4;
    localparam int TIME_W        = 17;
    localparam int TOTAL_W       = 20;
    localparam int UNIT_W        = 21;
    localparam int DT_W          = 15;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 64;

    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

    localparam logic [CFG_IDX_W-1:0] REG_LOOP_MODE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_TOTAL = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DUR_FIRST   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DUR_SECOND  = 2'd3;

    localparam logic CMD_ADVANCE = 1'b0;
    localparam logic CMD_RESTART = 1'b1;

    typedef struct packed {
        logic               command;
        logic signed [15:0] elapsed_ticks;
    } t_in_word;

    typedef struct packed {
        logic [2:0] current_frame;
        logic       frame_valid;
        logic       done_res;
    } t_out_word;

    function automatic logic [SLOT_BITS-1:0] frame_dur(
        input logic [CFG_DATA_W-1:0] first,
        input logic [CFG_DATA_W-1:0] second,
        input logic [POS_W-1:0]      idx
    );
        logic [CFG_DATA_W-1:0] word;
        logic [SLOT_BITS-1:0]  slot;
        logic [SLOT_BITS-1:0]  mask;
        word = idx[2] ? second : first;
        slot = word[idx[1:0]*SLOT_BITS +: SLOT_BITS];
        mask = SLOT_BITS'((32'd1 << DURATION_BITS) - 32'd1);
        return slot & mask;
    endfunction

endpackage

// File: design/frame_duration_sequencer.sv
// Top level of the frame duration sequencer: sequencer, shared adder unit and output register.
// Each input word is accepted in the idle state, then the control walks over the frame table with a
// single shared add/subtract unit and returns the resulting frame in the output register.
// A restart, or an advance with no frames or a finished run, goes straight to the output load. An
// advance passes through the saturating add, the sum of the table frame by frame, the frame
// tests of the walk and, in loop mode, a bitwise modulo of the time by the table total (at most
// one per word), then the output load. A looping table whose durations total zero skips the
// walk. The input stalls from acceptance until the result is loaded; a waiting result does not
// stop the next word from being accepted, but that word is not loaded until the result is taken.
module frame_duration_sequencer (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  fds_pkg::t_in_word                 i_in_word,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output fds_pkg::t_out_word                o_out_word,
    input  logic                              i_cfg_we,
    input  logic [fds_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [fds_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_ADD  = 6'b000010,
        ST_SUM  = 6'b000100,
        ST_WALK = 6'b001000,
        ST_MOD  = 6'b010000,
        ST_FIN  = 6'b100000
    } t_state;

    t_state                             r_state, n_state;
    logic                               r_loop_mode;
    logic [fds_pkg::COUNT_W-1:0]        r_frame_total;
    logic [fds_pkg::CFG_DATA_W-1:0]     r_dur_first;
    logic [fds_pkg::CFG_DATA_W-1:0]     r_dur_second;

    logic [fds_pkg::POS_W-1:0]          r_pos, n_pos;
    logic [fds_pkg::TIME_W-1:0]         r_time, n_time;
    logic                               r_end, n_end;
    logic [fds_pkg::DT_W-1:0]           r_dt, n_dt;
    logic [fds_pkg::TOTAL_W-1:0]        r_total, n_total;
    logic [fds_pkg::POS_W-1:0]          r_idx, n_idx;
    logic                               r_modded, n_modded;
    logic [fds_pkg::UNIT_W-1:0]         r_rem, n_rem;
    logic [4:0]                         r_bit, n_bit;
    logic                               r_out_valid;
    fds_pkg::t_out_word                 r_out_word;

    logic [fds_pkg::COUNT_W-1:0]        w_count;
    logic                               w_accept;
    logic                               w_out_load;
    logic [fds_pkg::POS_W-1:0]          w_pos_sat;
    logic [fds_pkg::SLOT_BITS-1:0]      w_dur;
    logic [fds_pkg::COUNT_W-1:0]        w_pos_inc;
    logic [fds_pkg::UNIT_W-1:0]         w_shifted;
    logic [fds_pkg::UNIT_W-1:0]         w_a, w_b;
    logic                               w_sub;
    logic [fds_pkg::UNIT_W:0]           w_res;

    assign w_count = (r_frame_total > fds_pkg::COUNT_W'(fds_pkg::MAX_FRAMES))
                   ? fds_pkg::COUNT_W'(fds_pkg::MAX_FRAMES) : r_frame_total;
    assign w_accept   = i_in_valid && (r_state == ST_IDLE);
    assign w_out_load = (r_state == ST_FIN) && (!r_out_valid || !i_out_stall);
    assign o_in_stall = (r_state != ST_IDLE);

    assign w_pos_sat = ((w_count != '0) && ({1'b0, r_pos} >= w_count))
                     ? fds_pkg::POS_W'(w_count - 4'd1) : r_pos;
    assign w_dur = fds_pkg::frame_dur(r_dur_first, r_dur_second,
                                      (r_state == ST_SUM) ? r_idx : r_pos);
    assign w_pos_inc = {1'b0, r_pos} + 4'd1;
    assign w_shifted = {r_rem[fds_pkg::UNIT_W-2:0], r_time[r_bit]};

    always_comb begin
        w_a   = '0;
        w_b   = '0;
        w_sub = 1'b0;
        case (r_state)
            ST_ADD: begin
                w_a = fds_pkg::UNIT_W'(r_time);
                w_b = fds_pkg::UNIT_W'(r_dt);
            end
            ST_SUM: begin
                w_a = fds_pkg::UNIT_W'(r_total);
                w_b = fds_pkg::UNIT_W'(w_dur);
            end
            ST_WALK: begin
                w_a   = fds_pkg::UNIT_W'(r_time);
                w_b   = fds_pkg::UNIT_W'(w_dur);
                w_sub = 1'b1;
            end
            ST_MOD: begin
                w_a   = w_shifted;
                w_b   = fds_pkg::UNIT_W'(r_total);
                w_sub = 1'b1;
            end
            default: begin
                w_sub = 1'b0;
            end
        endcase
    end

    // With subtraction the top bit of the result is set when a is not below b.
    assign w_res = {1'b0, w_a} + {1'b0, (w_sub ? ~w_b : w_b)}
                 + {{fds_pkg::UNIT_W{1'b0}}, w_sub};

    always_comb begin
        n_state  = r_state;
        n_pos    = r_pos;
        n_time   = r_time;
        n_end    = r_end;
        n_dt     = r_dt;
        n_total  = r_total;
        n_idx    = r_idx;
        n_modded = r_modded;
        n_rem    = r_rem;
        n_bit    = r_bit;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_pos    = w_pos_sat;
                    n_dt     = i_in_word.elapsed_ticks[15] ? '0
                             : i_in_word.elapsed_ticks[fds_pkg::DT_W-1:0];
                    n_total  = '0;
                    n_idx    = '0;
                    n_modded = 1'b0;
                    if (i_in_word.command == fds_pkg::CMD_RESTART) begin
                        n_pos   = '0;
                        n_time  = '0;
                        n_end   = 1'b0;
                        n_state = ST_FIN;
                    end else if ((w_count == '0) || r_end) begin
                        n_state = ST_FIN;
                    end else begin
                        n_state = ST_ADD;
                    end
                end
            end
            ST_ADD: begin
                n_time  = (w_res > {{(fds_pkg::UNIT_W + 1 - fds_pkg::TIME_W){1'b0}},
                                    fds_pkg::TIME_MAX})
                        ? fds_pkg::TIME_MAX : w_res[fds_pkg::TIME_W-1:0];
                n_state = ST_SUM;
            end
            ST_SUM: begin
                n_total = w_res[fds_pkg::TOTAL_W-1:0];
                n_idx   = r_idx + 3'd1;
                if ({1'b0, r_idx} == (w_count - 4'd1)) begin
                    if (r_loop_mode && (w_res[fds_pkg::TOTAL_W-1:0] == '0)) begin
                        n_state = ST_FIN;
                    end else begin
                        n_state = ST_WALK;
                    end
                end
            end
            ST_WALK: begin
                if (r_loop_mode && (r_pos == '0) && !r_modded) begin
                    n_rem   = '0;
                    n_bit   = 5'(fds_pkg::TIME_W - 1);
                    n_state = ST_MOD;
                end else if (!w_res[fds_pkg::UNIT_W]) begin
                    n_state = ST_FIN;
                end else begin
                    n_time   = w_res[fds_pkg::TIME_W-1:0];
                    n_modded = 1'b0;
                    if (w_pos_inc < w_count) begin
                        n_pos = w_pos_inc[fds_pkg::POS_W-1:0];
                    end else if (r_loop_mode) begin
                        n_pos = '0;
                    end else begin
                        n_pos   = fds_pkg::POS_W'(w_count - 4'd1);
                        n_end   = 1'b1;
                        n_state = ST_FIN;
                    end
                end
            end
            ST_MOD: begin
                n_rem = w_res[fds_pkg::UNIT_W] ? w_res[fds_pkg::UNIT_W-1:0] : w_shifted;
                n_bit = r_bit - 5'd1;
                if (r_bit == '0) begin
                    n_time   = n_rem[fds_pkg::TIME_W-1:0];
                    n_modded = 1'b1;
                    n_state  = ST_WALK;
                end
            end
            ST_FIN: begin
                if (w_out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_loop_mode   <= 1'b1;
            r_frame_total <= '0;
            r_dur_first   <= '0;
            r_dur_second  <= '0;
            r_pos         <= '0;
            r_time        <= '0;
            r_end         <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pos   <= n_pos;
            r_time  <= n_time;
            r_end   <= n_end;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    fds_pkg::REG_LOOP_MODE:   r_loop_mode   <= i_cfg_data[0];
                    fds_pkg::REG_FRAME_TOTAL: r_frame_total <= i_cfg_data[fds_pkg::COUNT_W-1:0];
                    fds_pkg::REG_DUR_FIRST:   r_dur_first   <= i_cfg_data;
                    fds_pkg::REG_DUR_SECOND:  r_dur_second  <= i_cfg_data;
                    default:                  r_loop_mode   <= r_loop_mode;
                endcase
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_dt     <= n_dt;
        r_total  <= n_total;
        r_idx    <= n_idx;
        r_modded <= n_modded;
        r_rem    <= n_rem;
        r_bit    <= n_bit;
        if (w_out_load) begin
            r_out_word.current_frame <= (w_count != '0) ? r_pos : '0;
            r_out_word.frame_valid   <= (w_count != '0);
            r_out_word.done_res      <= r_end;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> o_in_stall)
        else $error("Input was not stalled after a word was accepted.");

    a_mod_nonzero_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MOD) |-> (r_total != '0))
        else $error("Modulo started with a zero table total.");

    a_walk_pos_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WALK) |-> ({1'b0, r_pos} < w_count))
        else $error("Frame position left the table during the walk.");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FIN && r_out_valid && i_out_stall) |=> (r_state == ST_FIN))
        else $error("Finished word overwrote a pending result.");

endmodule

// File: sim/frame_duration_sequencer_test.sv
`timescale 1ns / 100ps
// Self-checking testbench of the frame duration sequencer: directed table, random words, predictor.
module frame_duration_sequencer_test;

    localparam int RANDOM_WORDS = 1850;
    localparam int HOLD_CYCLES  = 400;
    localparam int QUIET_LIMIT  = 4000;
    localparam int SETTLE       = 4;

    typedef enum logic {ROW_WRITE, ROW_WORD} t_row_kind;

    typedef struct {
        t_row_kind                       kind;
        logic [fds_pkg::CFG_IDX_W-1:0]   index;
        logic [fds_pkg::CFG_DATA_W-1:0]  data;
        fds_pkg::t_in_word               word;
        bit                              typed;
        fds_pkg::t_out_word              want;
    } t_script_row;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            i_in_valid = 1'b0;
    logic                            o_in_stall;
    fds_pkg::t_in_word               i_in_word = '0;
    logic                            o_out_valid;
    logic                            i_out_stall = 1'b0;
    fds_pkg::t_out_word              o_out_word;
    logic                            i_cfg_we = 1'b0;
    logic [fds_pkg::CFG_IDX_W-1:0]   i_cfg_index = '0;
    logic [fds_pkg::CFG_DATA_W-1:0]  i_cfg_data = '0;

    logic                            mirror_loop;
    logic [fds_pkg::COUNT_W-1:0]     mirror_total;
    logic [fds_pkg::CFG_DATA_W-1:0]  mirror_first;
    logic [fds_pkg::CFG_DATA_W-1:0]  mirror_second;
    int unsigned                     model_pos;
    int unsigned                     model_time;
    bit                              model_ended;

    fds_pkg::t_out_word              expected_frames[$];
    fds_pkg::t_out_word              want;
    t_script_row                     script[$];
    bit                              calm = 1'b0;
    bit                              hold_req = 1'b0;
    int                              mismatches = 0;
    int                              results_checked = 0;
    int                              words_sent = 0;
    int                              reg_writes = 0;

    frame_duration_sequencer DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int unsigned slot_ticks(input int unsigned idx);
        logic [fds_pkg::CFG_DATA_W-1:0] table_word;
        logic [fds_pkg::POS_W-1:0]      sel;
        logic [15:0]                    slot;
        sel = idx[fds_pkg::POS_W-1:0];
        table_word = sel[2] ? mirror_second : mirror_first;
        slot = table_word[sel[1:0]*16 +: 16];
        return int'(slot) & ((32'd1 << fds_pkg::DURATION_BITS) - 32'd1);
    endfunction

    function automatic fds_pkg::t_out_word predict_frame(input fds_pkg::t_in_word w);
        int unsigned        count;
        int unsigned        dt;
        int unsigned        sum;
        int unsigned        d;
        int unsigned        i;
        fds_pkg::t_out_word r;
        count = (mirror_total > fds_pkg::MAX_FRAMES) ? fds_pkg::MAX_FRAMES : int'(mirror_total);
        if (count != 0 && model_pos >= count) begin
            model_pos = count - 1;
        end
        if (w.command == fds_pkg::CMD_RESTART) begin
            model_pos = 0;
            model_time = 0;
            model_ended = 1'b0;
        end else if (count != 0 && !model_ended) begin
            dt = w.elapsed_ticks[15] ? 0 : int'(w.elapsed_ticks[14:0]);
            model_time = model_time + dt;
            if (model_time > fds_pkg::TIME_MAX) begin
                model_time = fds_pkg::TIME_MAX;
            end
            sum = 0;
            for (i = 0; i < count; i++) begin
                sum += slot_ticks(i);
            end
            if (!(mirror_loop && sum == 0)) begin
                while (!model_ended) begin
                    if (mirror_loop && model_pos == 0) begin
                        model_time = model_time % sum;
                    end
                    d = slot_ticks(model_pos);
                    if (model_time < d) begin
                        break;
                    end
                    model_time -= d;
                    model_pos++;
                    if (model_pos >= count) begin
                        if (mirror_loop) begin
                            model_pos = 0;
                        end else begin
                            model_pos = count - 1;
                            model_ended = 1'b1;
                        end
                    end
                end
            end
        end
        r.current_frame = (count != 0) ? model_pos[2:0] : 3'd0;
        r.frame_valid = (count != 0);
        r.done_res = model_ended;
        return r;
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic fds_pkg::t_in_word rand_word();
        fds_pkg::t_in_word w;
        int unsigned       r;
        r = $urandom_range(0, 99);
        w.command = (r < 8) ? fds_pkg::CMD_RESTART : fds_pkg::CMD_ADVANCE;
        r = $urandom_range(0, 99);
        if (r < 45) w.elapsed_ticks = 16'($urandom_range(0, 60));
        else if (r < 60) w.elapsed_ticks = 16'($urandom_range(0, 600));
        else if (r < 75) w.elapsed_ticks = {1'b1, 15'($urandom)};
        else if (r < 85) w.elapsed_ticks = 16'($urandom);
        else if (r < 92) w.elapsed_ticks = 16'h7FFF;
        else if (r < 96) w.elapsed_ticks = 16'h8000;
        else w.elapsed_ticks = 16'h0000;
        return w;
    endfunction

    function automatic logic [fds_pkg::CFG_DATA_W-1:0] rand_durations();
        logic [fds_pkg::CFG_DATA_W-1:0] v;
        int unsigned                    r;
        int                             s;
        for (s = 0; s < 4; s++) begin
            r = $urandom_range(0, 99);
            if (r < 20) v[s*16 +: 16] = 16'h0000;
            else if (r < 70) v[s*16 +: 16] = 16'($urandom_range(1, 40));
            else if (r < 85) v[s*16 +: 16] = 16'($urandom_range(41, 1000));
            else if (r < 95) v[s*16 +: 16] = 16'($urandom);
            else v[s*16 +: 16] = 16'hFFFF;
        end
        return v;
    endfunction

    function automatic logic [fds_pkg::CFG_DATA_W-1:0] rand_frame_total();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 10) return '0;
        if (r < 20) return fds_pkg::CFG_DATA_W'(fds_pkg::MAX_FRAMES);
        if (r < 30) return fds_pkg::CFG_DATA_W'($urandom_range(fds_pkg::MAX_FRAMES + 1, 15));
        return fds_pkg::CFG_DATA_W'($urandom_range(1, fds_pkg::MAX_FRAMES));
    endfunction

    function automatic void add_write(input logic [fds_pkg::CFG_IDX_W-1:0] idx,
                                      input logic [fds_pkg::CFG_DATA_W-1:0] data);
        t_script_row row;
        row = '{ROW_WRITE, idx, data, '0, 1'b0, '0};
        script.insert(script.size(), row);
    endfunction

    function automatic void add_word(input logic cmd, input logic [15:0] ticks,
                                     input bit typed, input fds_pkg::t_out_word exp_word);
        t_script_row row;
        row = '{ROW_WORD, '0, '0, {cmd, ticks}, typed, exp_word};
        script.insert(script.size(), row);
    endfunction

    task automatic write_reg(input logic [fds_pkg::CFG_IDX_W-1:0] idx,
                             input logic [fds_pkg::CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        case (idx)
            fds_pkg::REG_LOOP_MODE: begin
                mirror_loop = data[0];
            end
            fds_pkg::REG_FRAME_TOTAL: begin
                mirror_total = data[fds_pkg::COUNT_W-1:0];
            end
            fds_pkg::REG_DUR_FIRST: begin
                mirror_first = data;
            end
            default: begin
                mirror_second = data;
            end
        endcase
        reg_writes++;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic offer_word(input fds_pkg::t_in_word w, input bit typed,
                              input fds_pkg::t_out_word exp_word);
        fds_pkg::t_out_word predicted;
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in_word <= w;
        do @(posedge i_clk); while (o_in_stall);
        predicted = predict_frame(w);
        expected_frames.insert(expected_frames.size(), typed ? exp_word : predicted);
        words_sent++;
    endtask

    task automatic sender_pause(input int unsigned n);
        if (n > 0) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            i_in_word <= rand_word();
            repeat (n - 1) @(negedge i_clk);
        end
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (expected_frames.size() != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    // Output side: random stall bursts, plus one long hold-off on request.
    initial begin : receiver
        int unsigned stall_left;
        int unsigned run_left;
        int unsigned hold_left;
        stall_left = 0;
        run_left = 0;
        hold_left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                i_out_stall <= 1'b1;
                hold_left--;
            end else if (hold_req) begin
                hold_req = 1'b0;
                hold_left = HOLD_CYCLES - 1;
                i_out_stall <= 1'b1;
            end else begin
                if (stall_left == 0 && run_left == 0) begin
                    stall_left = calm ? 0 : pick_gap();
                    run_left = $urandom_range(1, 8);
                end
                if (stall_left > 0) begin
                    i_out_stall <= 1'b1;
                    stall_left--;
                end else begin
                    i_out_stall <= 1'b0;
                    run_left--;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_frames.size() == 0) begin
                $display("%0t: word %h arrived with nothing expected", $time, o_out_word);
                mismatches++;
            end else begin
                want = expected_frames.pop_front();
                results_checked++;
                if (o_out_word.current_frame !== want.current_frame) begin
                    $display("%0t: current_frame expected %0d, got %0d", $time,
                             want.current_frame, o_out_word.current_frame);
                    mismatches++;
                end
                if (o_out_word.frame_valid !== want.frame_valid) begin
                    $display("%0t: frame_valid expected %0b, got %0b", $time,
                             want.frame_valid, o_out_word.frame_valid);
                    mismatches++;
                end
                if (o_out_word.done_res !== want.done_res) begin
                    $display("%0t: done_res expected %0b, got %0b", $time,
                             want.done_res, o_out_word.done_res);
                    mismatches++;
                end
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("Test completed with failures");
        $finish;
    end

    initial begin : stimulus
        int          idx;
        int          phase;
        int          random_words;
        int          directed_words;
        int unsigned n;
        int unsigned k;
        mirror_loop = 1'b1;
        mirror_total = '0;
        mirror_first = '0;
        mirror_second = '0;
        model_pos = 0;
        model_time = 0;
        model_ended = 1'b0;

        // With no frames the sequencer reports no valid frame; an all-zero looping table saturates time.
        add_word(fds_pkg::CMD_ADVANCE, 16'h7FFF, 1'b1, {3'd0, 1'b0, 1'b0});
        add_word(fds_pkg::CMD_RESTART, 16'h0000, 1'b1, {3'd0, 1'b0, 1'b0});
        add_write(fds_pkg::REG_FRAME_TOTAL, 64'd3);
        add_word(fds_pkg::CMD_ADVANCE, 16'h8000, 1'b1, {3'd0, 1'b1, 1'b0});
        repeat (5) add_word(fds_pkg::CMD_ADVANCE, 16'h7FFF, 1'b1, {3'd0, 1'b1, 1'b0});
        add_write(fds_pkg::REG_DUR_FIRST, 64'hFFFF_0014_0000_000A);
        add_word(fds_pkg::CMD_ADVANCE, 16'h0000, 1'b0, '0);
        add_word(fds_pkg::CMD_ADVANCE, 16'd25, 1'b0, '0);
        add_write(fds_pkg::REG_LOOP_MODE, 64'd0);
        add_word(fds_pkg::CMD_ADVANCE, 16'h7FFF, 1'b0, '0);
        add_word(fds_pkg::CMD_ADVANCE, 16'd100, 1'b0, '0);
        add_word(fds_pkg::CMD_RESTART, 16'hFFFF, 1'b1, {3'd0, 1'b1, 1'b0});
        add_write(fds_pkg::REG_DUR_SECOND, 64'hFFFF_FFFF_FFFF_FFFF);
        add_write(fds_pkg::REG_FRAME_TOTAL, 64'd15);
        add_word(fds_pkg::CMD_ADVANCE, 16'd9, 1'b0, '0);
        add_word(fds_pkg::CMD_ADVANCE, 16'd1, 1'b0, '0);
        add_word(fds_pkg::CMD_ADVANCE, 16'hFFFF, 1'b0, '0);
        repeat (3) add_word(fds_pkg::CMD_ADVANCE, 16'h7FFF, 1'b0, '0);
        // Lowering the count leaves the position past the end of the table.
        add_write(fds_pkg::REG_FRAME_TOTAL, 64'd2);
        add_word(fds_pkg::CMD_ADVANCE, 16'h0000, 1'b0, '0);
        add_write(fds_pkg::REG_FRAME_TOTAL, 64'd0);
        add_word(fds_pkg::CMD_ADVANCE, 16'd5, 1'b0, '0);
        add_word(fds_pkg::CMD_RESTART, 16'h7FFF, 1'b1, {3'd0, 1'b0, 1'b0});
        add_write(fds_pkg::REG_FRAME_TOTAL, 64'd3);
        add_write(fds_pkg::REG_DUR_FIRST, 64'd0);
        add_word(fds_pkg::CMD_ADVANCE, 16'd1, 1'b1, {3'd2, 1'b1, 1'b1});
        add_word(fds_pkg::CMD_RESTART, 16'h0000, 1'b1, {3'd0, 1'b1, 1'b0});

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (idx = 0; idx < script.size(); idx++) begin
            if (script[idx].kind == ROW_WRITE) begin
                drain_results();
                write_reg(script[idx].index, script[idx].data);
            end else begin
                offer_word(script[idx].word, script[idx].typed, script[idx].want);
                sender_pause(pick_gap());
            end
        end
        directed_words = words_sent;

        phase = 0;
        random_words = 0;
        while (random_words < RANDOM_WORDS) begin
            drain_results();
            calm = (phase % 4 == 2);
            if (phase == 0 || $urandom_range(0, 9) < 6) begin
                write_reg(fds_pkg::REG_LOOP_MODE, 64'($urandom_range(0, 1)));
            end
            if (phase == 0 || $urandom_range(0, 9) < 6) begin
                write_reg(fds_pkg::REG_FRAME_TOTAL, rand_frame_total());
            end
            if (phase == 0 || $urandom_range(0, 9) < 6) begin
                write_reg(fds_pkg::REG_DUR_FIRST, rand_durations());
            end
            if (phase == 0 || $urandom_range(0, 9) < 6) begin
                write_reg(fds_pkg::REG_DUR_SECOND, rand_durations());
            end
            n = $urandom_range(15, 70);
            // Hold the output off for a long stretch while words keep coming back to back.
            if (phase == 5) begin
                calm = 1'b1;
                hold_req = 1'b1;
                n = 30;
            end
            if (n > RANDOM_WORDS - random_words) begin
                n = RANDOM_WORDS - random_words;
            end
            for (k = 0; k < n; k++) begin
                offer_word(rand_word(), 1'b0, '0);
                random_words++;
                sender_pause(calm ? 0 : pick_gap());
            end
            phase++;
        end
        drain_results();
        repeat (8) @(negedge i_clk);

        $display("Sent %0d words (%0d from the directed table) over %0d phases.",
                 words_sent, directed_words, phase);
        $display("Checked %0d results after %0d register writes on tables of 0 to 15 frames.",
                 results_checked, reg_writes);
        if (mismatches == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// File: sim.f
design/fds_pkg.sv
design/frame_duration_sequencer.sv
sim/frame_duration_sequencer_test.sv
